/* sv/abtt_pkg.sv */
// ----------------------------------------------------------------------------
// abtt_pkg
// Shared types and constants for the array-backed binary tree table.
// ----------------------------------------------------------------------------
`default_nettype none

package abtt_pkg;

   // field widths of one request and one response item
   localparam int ACTION_W  = 3;
   localparam int KEY_W     = 16;
   localparam int NEWVAL_W  = 16;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 8;
   localparam int PVAL_W    = 16;
   localparam int HEIGHT_W  = 4;

   // packed stream widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - STATUS_W - INDEX_W - PVAL_W;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 4'd8;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_SET_ROOT  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SET_LEFT  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SET_RIGHT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_GET_PAR   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ROOT_RD,
      S_ROOT_CHK,
      S_SEARCH,
      S_FOUND,
      S_PARENT,
      S_SWEEP,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

/* sv/array_binary_tree_table.sv */
// one item at a time: a request is taken only in the idle state, and the next one only after
// the response of the last has been loaded into the output register. A search reads the slots
// in index order up to the slots in use; remove then clears the subtree level by level.
// reset: synchronous; afterwards a clearing pass over all 2^MAX_HEIGHT-1 slots (255 by
// default) empties the occupied memory while req_tready stays low.
// ----------------------------------------------------------------------------
// array_binary_tree_table
// Binary tree held in an implicit slot array with value and occupied memories.
// ----------------------------------------------------------------------------
`default_nettype none

module array_binary_tree_table #(
   parameter int MAX_HEIGHT  = 8,
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // action [2:0], key [18:3], new_value [34:19]
   input  wire logic [abtt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status [1:0], node_index [9:2], parent_value [25:10]
   output logic [abtt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                            csr_we,
   // tree_height [3:0]
   input  wire logic [abtt_pkg::HEIGHT_W-1:0]   csr_wdata
);
   import abtt_pkg::*;

   localparam int SLOT_COUNT = (1 << MAX_HEIGHT) - 1;
   localparam int ADDR_W     = MAX_HEIGHT;
   localparam int CNT_W      = MAX_HEIGHT + 1;
   localparam int HW         = $clog2(MAX_HEIGHT + 1);
   localparam int CMP_W      = (VALUE_WIDTH > KEY_W) ? VALUE_WIDTH : KEY_W;

   // slot memories
   logic [VALUE_WIDTH-1:0] val_mem [SLOT_COUNT];
   logic                   occ_mem [SLOT_COUNT];
   logic [VALUE_WIDTH-1:0] val_q;
   logic                   occ_q;

   logic [ADDR_W-1:0]      rd_addr;
   logic                   val_we;
   logic [ADDR_W-1:0]      val_waddr;
   logic [VALUE_WIDTH-1:0] val_wdata;
   logic                   occ_we;
   logic [ADDR_W-1:0]      occ_waddr;
   logic                   occ_wdata;

   state_type state_ff, state_in;

   logic [HEIGHT_W-1:0]    height_ff;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [ADDR_W-1:0]      scan_ff, scan_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0]      cmp_addr_ff, cmp_addr_in;
   logic [ADDR_W-1:0]      found_ff, found_in;
   logic [CNT_W-1:0]       lo_ff, lo_in;
   logic [CNT_W-1:0]       hi_ff, hi_in;
   logic [CNT_W-1:0]       sweep_ff, sweep_in;
   logic [ACTION_W-1:0]    act_ff, act_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [VALUE_WIDTH-1:0] nv_ff, nv_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [INDEX_W-1:0]     res_index_ff, res_index_in;
   logic [PVAL_W-1:0]      res_pval_ff, res_pval_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [ACTION_W-1:0]    req_action;
   logic [KEY_W-1:0]       req_key;
   logic [NEWVAL_W-1:0]    req_new_value;
   logic                   req_fire;
   logic                   height_over;
   logic [HW-1:0]          height_eff;
   logic [CNT_W-1:0]       in_use;
   logic                   issuing;
   logic                   hit;
   logic                   miss;
   logic [CNT_W-1:0]       child;
   logic                   child_ok;
   logic [ADDR_W-1:0]      parent;
   logic [CNT_W-1:0]       lo_next;
   logic [CNT_W-1:0]       hi_next;
   logic                   sweep_last;
   logic                   level_done;
   logic                   clr_last;
   logic                   out_free;

   assign req_action    = req_tdata[2:0];
   assign req_key       = req_tdata[18:3];
   assign req_new_value = req_tdata[34:19];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // slots in use: 2^h - 1 with h clamped to the table height
   assign height_over = {1'b0, height_ff} > 5'(MAX_HEIGHT);
   assign height_eff  = height_over ? HW'(MAX_HEIGHT) : HW'(height_ff);
   assign in_use      = (CNT_W'(1) << height_eff) - CNT_W'(1);

   // search compares the slot read last cycle; a key bit above the value width never matches
   assign issuing = CNT_W'(scan_ff) < in_use;
   assign hit     = cmp_valid_ff && occ_q && (CMP_W'(val_q) == CMP_W'(key_ff));
   assign miss    = !hit && !cmp_valid_ff && !issuing;

   assign child    = (CNT_W'(found_ff) << 1) + CNT_W'(act_ff);
   assign child_ok = child < in_use;
   assign parent   = (found_ff == '0) ? '0 : ((found_ff - ADDR_W'(1)) >> 1);

   // subtree sweep walks one level range at a time
   assign lo_next    = (lo_ff << 1) + CNT_W'(1);
   assign hi_next    = (hi_ff << 1) + CNT_W'(2);
   assign sweep_last = (sweep_ff == hi_ff);
   assign level_done = lo_next >= CNT_W'(SLOT_COUNT);
   assign clr_last   = (clr_ff == ADDR_W'(SLOT_COUNT - 1));

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
   end

   always_ff @(posedge clock) begin
      val_q <= val_mem[rd_addr];
      occ_q <= occ_mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               priority if (req_action == ACT_SET_ROOT) begin
                  state_in = (in_use == '0) ? S_DONE : S_ROOT_RD;
               end else if (req_action == ACT_SET_LEFT || req_action == ACT_SET_RIGHT ||
                            req_action == ACT_GET_PAR || req_action == ACT_REMOVE) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ROOT_RD:  state_in = S_ROOT_CHK;
         S_ROOT_CHK: state_in = S_DONE;
         S_SEARCH: begin
            if (hit) state_in = S_FOUND;
            else if (miss) state_in = S_DONE;
         end
         S_FOUND: begin
            unique case (act_ff)
               ACT_GET_PAR: state_in = S_PARENT;
               ACT_REMOVE:  state_in = S_SWEEP;
               default:     state_in = S_DONE;
            endcase
         end
         S_PARENT: state_in = S_DONE;
         S_SWEEP: begin
            if (sweep_last && level_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      rd_addr       = '0;
      val_we        = 1'b0;
      val_waddr     = '0;
      val_wdata     = nv_ff;
      occ_we        = 1'b0;
      occ_waddr     = '0;
      occ_wdata     = 1'b0;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      cmp_valid_in  = 1'b0;
      cmp_addr_in   = cmp_addr_ff;
      found_in      = found_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      sweep_in      = sweep_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      nv_in         = nv_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_pval_in   = res_pval_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            occ_we    = 1'b1;
            occ_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (req_fire) begin
               act_in        = req_action;
               key_in        = req_key;
               nv_in         = VALUE_WIDTH'(req_new_value);
               scan_in       = '0;
               res_status_in = ST_OK;
               res_index_in  = '0;
               res_pval_in   = '0;
               priority if (req_action == ACT_SET_ROOT) begin
                  if (in_use == '0) res_status_in = ST_REFUSED;
               end else if (req_action == ACT_SET_LEFT || req_action == ACT_SET_RIGHT ||
                            req_action == ACT_GET_PAR || req_action == ACT_REMOVE) begin
                  res_status_in = ST_OK;
               end else begin
                  res_status_in = ST_REFUSED;
               end
            end
         end
         S_ROOT_RD: begin
            rd_addr = '0;
         end
         S_ROOT_CHK: begin
            if (occ_q) begin
               res_status_in = ST_REFUSED;
            end else begin
               val_we    = 1'b1;
               val_waddr = '0;
               occ_we    = 1'b1;
               occ_waddr = '0;
               occ_wdata = 1'b1;
            end
         end
         S_SEARCH: begin
            rd_addr      = scan_ff;
            cmp_addr_in  = scan_ff;
            cmp_valid_in = issuing && !hit;
            if (issuing) scan_in = scan_ff + ADDR_W'(1);
            if (hit) begin
               found_in = cmp_addr_ff;
            end else if (miss) begin
               res_status_in = ST_MISSING;
            end
         end
         S_FOUND: begin
            res_index_in = INDEX_W'(found_ff);
            unique case (act_ff)
               ACT_SET_LEFT, ACT_SET_RIGHT: begin
                  if (child_ok) begin
                     val_we       = 1'b1;
                     val_waddr    = child[ADDR_W-1:0];
                     occ_we       = 1'b1;
                     occ_waddr    = child[ADDR_W-1:0];
                     occ_wdata    = 1'b1;
                     res_index_in = INDEX_W'(child);
                  end else begin
                     res_status_in = ST_REFUSED;
                  end
               end
               ACT_GET_PAR: begin
                  rd_addr = parent;
               end
               ACT_REMOVE: begin
                  lo_in    = CNT_W'(found_ff);
                  hi_in    = CNT_W'(found_ff);
                  sweep_in = CNT_W'(found_ff);
               end
               default: begin
                  res_status_in = ST_REFUSED;
               end
            endcase
         end
         S_PARENT: begin
            res_pval_in = PVAL_W'(val_q);
         end
         S_SWEEP: begin
            occ_we    = 1'b1;
            occ_waddr = sweep_ff[ADDR_W-1:0];
            if (sweep_last) begin
               lo_in    = lo_next;
               hi_in    = hi_next;
               sweep_in = lo_next;
            end else begin
               sweep_in = sweep_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD_W'(0), res_pval_ff, res_index_ff, res_status_ff};
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) height_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmp_addr_ff   <= cmp_addr_in;
      found_ff      <= found_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      sweep_ff      <= sweep_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      nv_ff         <= nv_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_pval_ff   <= res_pval_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* sv/abtt_checker.sv */
// ----------------------------------------------------------------------------
// abtt_checker
// Port-level checks for the binary tree table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abtt_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [abtt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import abtt_pkg::*;

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // one item in flight: no second accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // after reset the clearing pass holds off requests and no response is shown
   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready && !rsp_tvalid)
      else $error("activity right after reset");

   // a missing key reports no slot and no parent value
   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_MISSING) |-> (rsp_tdata[25:2] == '0))
      else $error("missing key with nonzero fields");

endmodule

bind array_binary_tree_table abtt_checker u_abtt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/tree_table_checker.sv */
// ----------------------------------------------------------------------------
// tree_table_checker
// Watches the request, response and register ports of the tree table, keeps
// its own copy of the slot array and tree height, predicts one response per
// accepted request and compares responses in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_table_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // action [2:0], key [18:3], new_value [34:19]
   input  wire logic [abtt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status [1:0], node_index [9:2], parent_value [25:10]
   input  wire logic [abtt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            csr_we,
   // tree_height [3:0]
   input  wire logic [abtt_pkg::HEIGHT_W-1:0]   csr_wdata,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   n_ok,
   output int                                   n_missing,
   output int                                   n_refused
);
   timeunit 1ns;
   timeprecision 1ps;

   import abtt_pkg::*;

   localparam int LEVELS = 8;
   localparam int SLOTS  = (1 << LEVELS) - 1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  node_index;
      logic [PVAL_W-1:0]   parent_value;
   } tree_reply_type;

   logic [NEWVAL_W-1:0] slot_val [SLOTS];
   bit                  slot_used [SLOTS];
   logic [HEIGHT_W-1:0] height_reg;
   tree_reply_type      expected_replies [$];

   // applies one request to the shadow tree and returns the response it gives
   function automatic tree_reply_type predict_tree_reply(logic [ACTION_W-1:0] action,
                                                         logic [KEY_W-1:0] key,
                                                         logic [NEWVAL_W-1:0] nv);
      tree_reply_type r;
      int             h;
      int             n;
      int             at;
      int             child;
      int             lo;
      int             hi;
      bit             hit;
      r   = '0;
      h   = (int'(height_reg) > LEVELS) ? LEVELS : int'(height_reg);
      n   = (1 << h) - 1;
      hit = 1'b0;
      at  = 0;
      // first occupied slot in use that holds the key
      for (int i = 0; i < n; i++) begin
         if (!hit && slot_used[i] && slot_val[i] == key) begin
            hit = 1'b1;
            at  = i;
         end
      end
      case (action)
         ACT_SET_ROOT: begin
            if (n == 0 || slot_used[0]) begin
               r.status = ST_REFUSED;
            end else begin
               slot_val[0]  = nv;
               slot_used[0] = 1'b1;
               r.status     = ST_OK;
            end
         end
         ACT_SET_LEFT, ACT_SET_RIGHT: begin
            if (!hit) begin
               r.status = ST_MISSING;
            end else begin
               child = 2 * at + int'(action);
               if (child >= n) begin
                  r.status     = ST_REFUSED;
                  r.node_index = INDEX_W'(at);
               end else begin
                  slot_val[child]  = nv;
                  slot_used[child] = 1'b1;
                  r.status         = ST_OK;
                  r.node_index     = INDEX_W'(child);
               end
            end
         end
         ACT_GET_PAR: begin
            if (!hit) begin
               r.status = ST_MISSING;
            end else begin
               r.status       = ST_OK;
               r.node_index   = INDEX_W'(at);
               r.parent_value = slot_val[(at == 0) ? 0 : (at - 1) / 2];
            end
         end
         ACT_REMOVE: begin
            if (!hit) begin
               r.status = ST_MISSING;
            end else begin
               // clear level by level down to the bottom of the array
               lo = at;
               hi = at;
               while (lo < SLOTS) begin
                  for (int j = lo; j <= hi && j < SLOTS; j++)
                     slot_used[j] = 1'b0;
                  lo = 2 * lo + 1;
                  hi = 2 * hi + 2;
               end
               r.status     = ST_OK;
               r.node_index = INDEX_W'(at);
            end
         end
         default: begin
            r.status = ST_REFUSED;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      tree_reply_type want;
      tree_reply_type got;
      int             step;
      if (reset) begin
         height_reg = HEIGHT_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_val[i]  = '0;
         end
         expected_replies.delete();
         pending    <= 0;
         fail_count = 0;
         n_ok       = 0;
         n_missing  = 0;
         n_refused  = 0;
      end else begin
         step = 0;
         if (csr_we)
            height_reg = csr_wdata;
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(predict_tree_reply(
               req_tdata[ACTION_W-1:0],
               req_tdata[ACTION_W +: KEY_W],
               req_tdata[ACTION_W+KEY_W +: NEWVAL_W]));
            step++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tdata[STATUS_W-1:0];
            got.node_index   = rsp_tdata[STATUS_W +: INDEX_W];
            got.parent_value = rsp_tdata[STATUS_W+INDEX_W +: PVAL_W];
            if (expected_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%t unexpected item: status %0d index %0d parent %h", $realtime,
                           got.status, got.node_index, got.parent_value);
            end else begin
               want = expected_replies.pop_front();
               step--;
               if (got.status !== want.status || got.node_index !== want.node_index ||
                   got.parent_value !== want.parent_value) begin
                  fail_count++;
                  // fields shown as status, node index, parent value
                  if (fail_count <= 10)
                     $display("%t mismatch: expected %0d %0d %h, got %0d %0d %h",
                              $realtime, want.status, want.node_index, want.parent_value,
                              got.status, got.node_index, got.parent_value);
               end
            end
            case (got.status)
               ST_OK:      n_ok++;
               ST_MISSING: n_missing++;
               ST_REFUSED: n_refused++;
               default:    ;
            endcase
         end
         pending <= pending + step;
      end
   end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the tree table with a directed set of tree operations followed by
// random build, lookup and prune traffic over several tree heights, with
// random stalls on both streams; the checker module judges every response.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import abtt_pkg::*;

   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int PHASE_ITEMS = 158;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [HEIGHT_W-1:0]   csr_wdata  = '0;

   int fail_count;
   int pending;
   int n_ok;
   int n_missing;
   int n_refused;

   int                  ready_hold  = 0;
   int                  items_sent  = 0;
   int                  heights_run = 1;
   bit                  sender_gaps = 1'b1;
   logic [NEWVAL_W-1:0] value_pool [$];
   logic [HEIGHT_W-1:0] phase_heights [10] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2,
                                               4'd4, 4'd3, 4'd9, 4'd6, 4'd8};

   array_binary_tree_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   tree_table_checker table_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .n_ok       (n_ok),
      .n_missing  (n_missing),
      .n_refused  (n_refused)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 15);
      else
         return $urandom_range(20, 80);
   endfunction

   // response side back-pressure, with occasional long fully-ready runs
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         ready_hold <= idle_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= ($urandom_range(0, 99) < 10) ? $urandom_range(100, 400)
                                                    : $urandom_range(0, 12);
      end
   end

   task automatic send_item(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key,
                            logic [NEWVAL_W-1:0] nv);
      int gap;
      gap = (sender_gaps && $urandom_range(0, 99) < 45) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({nv, key, action});
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (action == ACT_SET_ROOT || action == ACT_SET_LEFT || action == ACT_SET_RIGHT) begin
         value_pool.push_back(nv);
         if (value_pool.size() > 32)
            void'(value_pool.pop_front());
      end
   endtask

   // hold off the sender until every outstanding item has answered
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_height(logic [HEIGHT_W-1:0] h);
      csr_we    <= 1'b1;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      heights_run++;
   endtask

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [NEWVAL_W-1:0] nv;
      int                  r;
      int                  back;
      int                  depth;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tree, root handling, children, parents, pruning
      send_item(ACT_GET_PAR,   16'h0000, 16'h0000);
      send_item(ACT_SET_LEFT,  16'hFFFF, 16'h0001);
      send_item(ACT_REMOVE,    16'h0000, 16'hFFFF);
      send_item(ACT_SET_ROOT,  16'h0000, 16'hFFFF);
      send_item(ACT_SET_ROOT,  16'hFFFF, 16'h0000);
      send_item(ACT_SET_LEFT,  16'hFFFF, 16'h0000);
      send_item(ACT_SET_RIGHT, 16'hFFFF, 16'h8000);
      send_item(ACT_GET_PAR,   16'hFFFF, 16'h0000);  // root is its own parent
      send_item(ACT_GET_PAR,   16'h0000, 16'hFFFF);
      send_item(ACT_SET_LEFT,  16'h0000, 16'h1234);
      send_item(ACT_SET_RIGHT, 16'h0000, 16'hFFFF);  // duplicate of the root value
      send_item(ACT_GET_PAR,   16'h1234, 16'h0000);
      send_item(ACT_SET_LEFT,  16'h8000, 16'h0000);
      send_item(ACT_SET_LEFT,  16'h0000, 16'h7777);  // overwrite a taken child
      send_item(ACT_REMOVE + 3'd1, 16'hFFFF, 16'hFFFF);
      send_item(ACT_REMOVE + 3'd2, 16'h0000, 16'h0000);
      send_item(ACT_REMOVE + 3'd3, 16'hA5A5, 16'h5A5A);
      send_item(ACT_REMOVE,    16'h0000, 16'h0000);
      send_item(ACT_GET_PAR,   16'h7777, 16'h0000);
      send_item(ACT_REMOVE,    16'hFFFF, 16'h0000);
      send_item(ACT_SET_ROOT,  16'h0000, 16'h5A5A);

      foreach (phase_heights[p]) begin
         drain();
         repeat (8) @(posedge clock);
         write_height(phase_heights[p]);
         sender_gaps = (p % 3 != 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               action = ACT_SET_ROOT;
            else if (r < 38)
               action = ACT_SET_LEFT;
            else if (r < 68)
               action = ACT_SET_RIGHT;
            else if (r < 84)
               action = ACT_GET_PAR;
            else if (r < 93)
               action = ACT_REMOVE;
            else
               action = ACT_REMOVE + ACTION_W'($urandom_range(1, 3));
            nv = ($urandom_range(0, 99) < 85) ? NEWVAL_W'($urandom_range(0, 1023))
                                              : NEWVAL_W'($urandom);
            // keys mostly name recently written nodes so the tree grows deep
            if (value_pool.size() > 0 && $urandom_range(0, 99) < 80) begin
               depth = (value_pool.size() < 16) ? value_pool.size() : 16;
               back  = $urandom_range(0, depth - 1);
               key   = value_pool[value_pool.size() - 1 - back];
            end else begin
               key = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 1023))
                                          : KEY_W'($urandom);
            end
            send_item(action, key, nv);
            if ($urandom_range(0, 199) == 0)
               drain();
         end
      end

      drain();
      repeat (600) @(posedge clock);
      $display("covered %0d items over %0d tree heights, including 0 and the maximum",
               items_sent, heights_run);
      $display("responses: %0d ok, %0d key not found, %0d refused",
               n_ok, n_missing, n_refused);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
sv/abtt_pkg.sv
sv/array_binary_tree_table.sv
sv/abtt_checker.sv
tb/tree_table_checker.sv
tb/testbench.sv
